// ===== rtl/tsmp_pkg.sv =====
// Shared types, codes and constants of the program map section parser.
// Used by tsmp_parse_core, tsmp_rsp_fifo and ts_program_map_parser_unit.
`default_nettype none

package tsmp_pkg;

   // Parser phase, one-hot
   typedef enum logic [9:0] {
      PH_IDLE  = 10'b00_0000_0001,
      PH_HDR   = 10'b00_0000_0010,
      PH_PTAG  = 10'b00_0000_0100,
      PH_PLEN  = 10'b00_0000_1000,
      PH_PSKIP = 10'b00_0001_0000,
      PH_ETYPE = 10'b00_0010_0000,
      PH_EHDR  = 10'b00_0100_0000,
      PH_ETAG  = 10'b00_1000_0000,
      PH_ELEN  = 10'b01_0000_0000,
      PH_ESKIP = 10'b10_0000_0000
   } phase_type;

   // Stream type codes
   localparam logic [7:0] ST_MPEG2_VIDEO   = 8'h01;
   localparam logic [7:0] ST_MPEG2_VIDEO_B = 8'h02;
   localparam logic [7:0] ST_MPEG2_AUDIO   = 8'h03;
   localparam logic [7:0] ST_MPEG2_AUDIO_B = 8'h04;
   localparam logic [7:0] ST_AC3_PRIV      = 8'h81;
   localparam logic [7:0] ST_H264          = 8'h1b;
   localparam logic [7:0] ST_PRIVATE       = 8'h06;

   // Reported stream kinds
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_VIDEO    = 3'd1;
   localparam logic [2:0] KIND_AUDIO    = 3'd2;
   localparam logic [2:0] KIND_H264     = 3'd3;
   localparam logic [2:0] KIND_TELETEXT = 3'd4;
   localparam logic [2:0] KIND_AC3      = 3'd5;

   // Finish status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   // Result kinds
   localparam logic RES_STREAM = 1'b0;
   localparam logic RES_FINISH = 1'b1;

   // Register indexes and reset values
   localparam logic [1:0] CSR_SERVICE_ID   = 2'd0;
   localparam logic [1:0] CSR_TELETEXT_TAG = 2'd1;
   localparam logic [1:0] CSR_AC3_TAG      = 2'd2;
   localparam logic [7:0] TELETEXT_TAG_RST = 8'd86;
   localparam logic [7:0] AC3_TAG_RST      = 8'd106;

   // Section layout
   localparam logic [11:0] MIN_SECTION  = 12'd9;
   localparam logic [11:0] MIN_ES_BYTES = 12'd5;
   localparam logic [11:0] MIN_LOOP     = 12'd2;
   localparam logic [3:0]  HDR_SID_HI   = 4'd0;
   localparam logic [3:0]  HDR_SID_LO   = 4'd1;
   localparam logic [3:0]  HDR_PLEN_HI  = 4'd7;
   localparam logic [3:0]  HDR_PLEN_LO  = 4'd8;
   localparam logic [3:0]  ES_PID_HI    = 4'd1;
   localparam logic [3:0]  ES_PID_LO    = 4'd2;
   localparam logic [3:0]  ES_LEN_HI    = 4'd3;

   // Stream payload widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // Result queue
   localparam int RSP_DEPTH = 3;
   localparam int RSP_CNT_W = 2;

   typedef struct packed {
      logic        last;
      logic [1:0]  status;
      logic [2:0]  stream_kind;
      logic [12:0] stream_pid;
      logic        kind;
   } result_type;

   // Results produced by one byte, stream result first
   typedef struct packed {
      logic [1:0] count;
      result_type r1;
      result_type r0;
   } res_bundle_type;

   function automatic logic [2:0] type_kind(input logic [7:0] st);
      logic [2:0] k;
      case (st)
         ST_MPEG2_VIDEO, ST_MPEG2_VIDEO_B:             k = KIND_VIDEO;
         ST_MPEG2_AUDIO, ST_MPEG2_AUDIO_B, ST_AC3_PRIV: k = KIND_AUDIO;
         ST_H264:                                       k = KIND_H264;
         default:                                       k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tsmp_parse_core.sv =====
// Byte-wise parser state and configuration registers of the section parser.
// Depends on tsmp_pkg for phase codes, stream kinds and the result bundle.
`default_nettype none

module tsmp_parse_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     first_byte,
   input  wire logic [11:0]              section_bytes,
   input  wire logic                     cfg_wr,
   input  wire logic [1:0]               cfg_index,
   input  wire logic [15:0]              cfg_data,
   output tsmp_pkg::res_bundle_type      res
);

   // Configuration registers
   logic [15:0] service_id_ff;
   logic [7:0]  teletext_tag_ff;
   logic [7:0]  ac3_tag_ff;

   // Parser state
   tsmp_pkg::phase_type phase_ff, phase_in;
   logic [11:0] bl_ff, bl_in;
   logic [3:0]  hc_ff, hc_in;
   logic [15:0] gs_ff, gs_in;
   logic [11:0] loop_ff, loop_in;
   logic [7:0]  dl_ff, dl_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  type_ff, type_in;
   logic [12:0] pid_ff, pid_in;
   logic [2:0]  kind_ff, kind_in;

   // Step scratch
   tsmp_pkg::phase_type cur_phase;
   logic [3:0]  cur_hc;
   logic        run;
   logic [11:0] loop_dec;
   logic [11:0] dlen_w;
   logic        want_es, want_end, want_pdesc, want_edesc;
   logic        st_emit, fin_emit;
   logic [1:0]  fin_status;
   tsmp_pkg::result_type st_res, fin_res;

   assign dlen_w   = {4'b0000, data_byte};
   assign loop_dec = loop_ff - tsmp_pkg::MIN_LOOP;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         service_id_ff   <= '0;
         teletext_tag_ff <= tsmp_pkg::TELETEXT_TAG_RST;
         ac3_tag_ff      <= tsmp_pkg::AC3_TAG_RST;
      end else if (cfg_wr) begin
         case (cfg_index)
            tsmp_pkg::CSR_SERVICE_ID:   service_id_ff   <= cfg_data;
            tsmp_pkg::CSR_TELETEXT_TAG: teletext_tag_ff <= cfg_data[7:0];
            tsmp_pkg::CSR_AC3_TAG:      ac3_tag_ff      <= cfg_data[7:0];
            default: ;
         endcase
      end
   end

   // Advance the parser by one byte
   always_comb begin
      phase_in   = phase_ff;
      bl_in      = bl_ff;
      hc_in      = hc_ff;
      gs_in      = gs_ff;
      loop_in    = loop_ff;
      dl_in      = dl_ff;
      tag_in     = tag_ff;
      type_in    = type_ff;
      pid_in     = pid_ff;
      kind_in    = kind_ff;
      cur_phase  = phase_ff;
      cur_hc     = hc_ff;
      run        = 1'b0;
      want_es    = 1'b0;
      want_end   = 1'b0;
      want_pdesc = 1'b0;
      want_edesc = 1'b0;
      st_emit    = 1'b0;
      fin_emit   = 1'b0;
      fin_status = tsmp_pkg::STATUS_OK;

      // Open a new section or count down the current one
      if (first_byte) begin
         if (section_bytes < tsmp_pkg::MIN_SECTION) begin
            fin_emit   = 1'b1;
            fin_status = tsmp_pkg::STATUS_SHORT;
         end else begin
            cur_phase = tsmp_pkg::PH_HDR;
            cur_hc    = tsmp_pkg::HDR_SID_HI;
            bl_in     = section_bytes - 12'd1;
            run       = 1'b1;
         end
      end else if (phase_ff != tsmp_pkg::PH_IDLE) begin
         bl_in = bl_ff - 12'd1;
         run   = 1'b1;
      end

      if (run) begin
         phase_in = cur_phase;
         hc_in    = cur_hc;
         case (cur_phase)
            tsmp_pkg::PH_HDR: begin
               case (cur_hc)
                  tsmp_pkg::HDR_SID_HI:  gs_in   = {data_byte, 8'h00};
                  tsmp_pkg::HDR_SID_LO:  gs_in   = {gs_ff[15:8], data_byte};
                  tsmp_pkg::HDR_PLEN_HI: loop_in = {data_byte[3:0], 8'h00};
                  tsmp_pkg::HDR_PLEN_LO: begin
                     loop_in = {loop_ff[11:8], data_byte};
                     if (gs_ff != service_id_ff) begin
                        fin_emit   = 1'b1;
                        fin_status = tsmp_pkg::STATUS_MISMATCH;
                     end else begin
                        want_pdesc = 1'b1;
                     end
                  end
                  default: ;
               endcase
               hc_in = cur_hc + 4'd1;
            end
            tsmp_pkg::PH_PTAG: begin
               tag_in   = data_byte;
               phase_in = tsmp_pkg::PH_PLEN;
            end
            tsmp_pkg::PH_PLEN: begin
               loop_in = loop_dec;
               if (dlen_w > bl_in) begin
                  // overlong descriptor ends the program loop
                  want_es = 1'b1;
               end else begin
                  loop_in = (dlen_w > loop_dec) ? 12'd0 : loop_dec - dlen_w;
                  dl_in   = data_byte;
                  if (data_byte == 8'd0) begin
                     want_pdesc = 1'b1;
                  end else begin
                     phase_in = tsmp_pkg::PH_PSKIP;
                  end
               end
            end
            tsmp_pkg::PH_PSKIP: begin
               dl_in = dl_ff - 8'd1;
               if (dl_in == 8'd0) begin
                  want_pdesc = 1'b1;
               end
            end
            tsmp_pkg::PH_ETYPE: begin
               type_in  = data_byte;
               kind_in  = tsmp_pkg::type_kind(data_byte);
               hc_in    = tsmp_pkg::ES_PID_HI;
               phase_in = tsmp_pkg::PH_EHDR;
            end
            tsmp_pkg::PH_EHDR: begin
               case (cur_hc)
                  tsmp_pkg::ES_PID_HI: pid_in  = {data_byte[4:0], 8'h00};
                  tsmp_pkg::ES_PID_LO: pid_in  = {pid_ff[12:8], data_byte};
                  tsmp_pkg::ES_LEN_HI: loop_in = {data_byte[3:0], 8'h00};
                  default: begin
                     loop_in    = {loop_ff[11:8], data_byte};
                     want_edesc = 1'b1;
                  end
               endcase
               hc_in = cur_hc + 4'd1;
            end
            tsmp_pkg::PH_ETAG: begin
               tag_in   = data_byte;
               phase_in = tsmp_pkg::PH_ELEN;
            end
            tsmp_pkg::PH_ELEN: begin
               loop_in = loop_dec;
               if (dlen_w > bl_in) begin
                  want_end = 1'b1;
               end else begin
                  // private stream: teletext tag wins over AC-3 tag
                  if (type_ff == tsmp_pkg::ST_PRIVATE) begin
                     if (tag_ff == teletext_tag_ff) begin
                        kind_in = tsmp_pkg::KIND_TELETEXT;
                     end else if (tag_ff == ac3_tag_ff) begin
                        kind_in = tsmp_pkg::KIND_AC3;
                     end
                  end
                  loop_in = (dlen_w > loop_dec) ? 12'd0 : loop_dec - dlen_w;
                  dl_in   = data_byte;
                  if (data_byte == 8'd0) begin
                     want_edesc = 1'b1;
                  end else begin
                     phase_in = tsmp_pkg::PH_ESKIP;
                  end
               end
            end
            tsmp_pkg::PH_ESKIP: begin
               dl_in = dl_ff - 8'd1;
               if (dl_in == 8'd0) begin
                  want_edesc = 1'b1;
               end
            end
            default: phase_in = tsmp_pkg::PH_IDLE;
         endcase

         // Resolve loop exits: descriptor loop, stream end, next entry
         if (want_edesc) begin
            if (loop_in > tsmp_pkg::MIN_LOOP) begin
               phase_in = tsmp_pkg::PH_ETAG;
            end else begin
               want_end = 1'b1;
            end
         end
         if (want_pdesc) begin
            if (loop_in > tsmp_pkg::MIN_LOOP) begin
               phase_in = tsmp_pkg::PH_PTAG;
            end else begin
               want_es = 1'b1;
            end
         end
         if (want_end) begin
            st_emit = (kind_in != tsmp_pkg::KIND_NONE);
            want_es = 1'b1;
         end
         if (want_es) begin
            if (bl_in >= tsmp_pkg::MIN_ES_BYTES) begin
               phase_in = tsmp_pkg::PH_ETYPE;
            end else begin
               fin_emit = 1'b1;
            end
         end
         if (fin_emit) begin
            phase_in = tsmp_pkg::PH_IDLE;
         end

         // Out of bytes: flush a stream whose header is complete, then finish
         if (phase_in != tsmp_pkg::PH_IDLE && bl_in == 12'd0) begin
            if ((phase_in == tsmp_pkg::PH_ETAG || phase_in == tsmp_pkg::PH_ELEN ||
                 phase_in == tsmp_pkg::PH_ESKIP) && kind_in != tsmp_pkg::KIND_NONE) begin
               st_emit = 1'b1;
            end
            fin_emit   = 1'b1;
            fin_status = tsmp_pkg::STATUS_OK;
         end
      end

      if (fin_emit) begin
         phase_in = tsmp_pkg::PH_IDLE;
      end
   end

   // Hold parser state between accepted bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tsmp_pkg::PH_IDLE;
         bl_ff    <= '0;
         hc_ff    <= '0;
         gs_ff    <= '0;
         loop_ff  <= '0;
         dl_ff    <= '0;
         tag_ff   <= '0;
         type_ff  <= '0;
         pid_ff   <= '0;
         kind_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         bl_ff    <= bl_in;
         hc_ff    <= hc_in;
         gs_ff    <= gs_in;
         loop_ff  <= loop_in;
         dl_ff    <= dl_in;
         tag_ff   <= tag_in;
         type_ff  <= type_in;
         pid_ff   <= pid_in;
         kind_ff  <= kind_in;
      end
   end

   // Build the results of this byte
   always_comb begin
      st_res.kind         = tsmp_pkg::RES_STREAM;
      st_res.stream_pid   = pid_in;
      st_res.stream_kind  = kind_in;
      st_res.status       = tsmp_pkg::STATUS_OK;
      st_res.last         = !fin_emit;
      fin_res.kind        = tsmp_pkg::RES_FINISH;
      fin_res.stream_pid  = '0;
      fin_res.stream_kind = tsmp_pkg::KIND_NONE;
      fin_res.status      = fin_status;
      fin_res.last        = 1'b1;
   end

   assign res.count = step_en ? ({1'b0, st_emit} + {1'b0, fin_emit}) : 2'd0;
   assign res.r0    = st_emit ? st_res : fin_res;
   assign res.r1    = fin_res;

   // Two results are always a stream followed by the finish
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      res.count == 2'd2 |-> res.r0.kind == tsmp_pkg::RES_STREAM &&
                            res.r1.kind == tsmp_pkg::RES_FINISH)
      else $error("result pair out of order");

   // A finish always leaves the parser idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && fin_emit |=> phase_ff == tsmp_pkg::PH_IDLE)
      else $error("parser not idle after finish");

   // Only streams of a known kind are reported
   a_known_kind: assert property (@(posedge clock) disable iff (reset)
      step_en && st_emit |-> kind_in != tsmp_pkg::KIND_NONE)
      else $error("stream reported without kind");

endmodule

`default_nettype wire

// ===== rtl/tsmp_rsp_fifo.sv =====
// Three-entry result queue that takes up to two results per cycle while at most one entry is held.
// Depends on tsmp_pkg for the result types and queue depth.
`default_nettype none

module tsmp_rsp_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tsmp_pkg::res_bundle_type    push,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tvalid,
   output tsmp_pkg::result_type             rsp_item,
   output logic                             can_accept
);

   tsmp_pkg::result_type slots_ff [tsmp_pkg::RSP_DEPTH];
   tsmp_pkg::result_type slots_in [tsmp_pkg::RSP_DEPTH];
   logic [tsmp_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic [tsmp_pkg::RSP_CNT_W-1:0] base;
   logic                           pop;

   assign pop        = (count_ff != '0) && rsp_tready;
   assign base       = count_ff - {{(tsmp_pkg::RSP_CNT_W-1){1'b0}}, pop};
   assign count_in   = base + push.count;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_item   = slots_ff[0];
   // room for two more results even without a pop
   assign can_accept = (count_ff <= 2'd1);

   // Shift out the head, then append new results behind the survivors
   always_comb begin
      for (int i = 0; i < tsmp_pkg::RSP_DEPTH; i++) begin
         slots_in[i] = slots_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < tsmp_pkg::RSP_DEPTH - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
      end
      for (int i = 0; i < tsmp_pkg::RSP_DEPTH; i++) begin
         if (push.count != 2'd0 && base == tsmp_pkg::RSP_CNT_W'(i)) begin
            slots_in[i] = push.r0;
         end
         if (push.count == 2'd2 && (base + 2'd1) == tsmp_pkg::RSP_CNT_W'(i)) begin
            slots_in[i] = push.r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < tsmp_pkg::RSP_DEPTH; i++) begin
         slots_ff[i] <= slots_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // New results arrive only when two entries are free
   a_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= 2'd1)
      else $error("result pushed without room");

   // A pop with nothing pushed shrinks the queue by one
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count wrong after pop");

   // A pair pushed while stalled grows the queue by two
   a_pair_push: assert property (@(posedge clock) disable iff (reset)
      !pop && push.count == 2'd2 |=> count_ff == $past(count_ff) + 2'd2)
      else $error("queue count wrong after pair push");

endmodule

`default_nettype wire

// ===== rtl/ts_program_map_parser_unit.sv =====
// Top level of the program map section parser: stream ports and CSR port.
// Depends on tsmp_pkg, tsmp_parse_core and tsmp_rsp_fifo.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: data_byte, section_bytes; tuser: first_byte
//   rsp      out  rsp_tvalid/tready     tdata: pid, kind, status; tuser: kind; tlast: last
//   csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One section byte is taken per cycle while req_tready is high; its results enter the
// result queue at the same clock edge and reach rsp through the queue's head register.
// A byte that gives both a stream and a finish result fills the queue past its accept
// limit, so req_tready drops while the queue drains. Reset clears the parser to idle,
// loads the register defaults and empties the queue; no sweep. csr_ready is always high.
// The user must write registers only while no section is open; the block has no check.
`default_nettype none

module ts_program_map_parser_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // data_byte [7:0], section_bytes [19:8], zero [23:20]
   input  wire logic [tsmp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // first_byte [0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // stream_pid [12:0], stream_kind [15:13], status [17:16], zero [23:18]
   output logic [tsmp_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // result_kind [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [15:0]                        csr_data
);

   tsmp_pkg::res_bundle_type res;
   tsmp_pkg::result_type     item;
   logic                     accept;
   logic                     can_accept;

   assign req_tready = can_accept;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Parse one request byte per accepted request
   tsmp_parse_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .data_byte     (req_tdata[7:0]),
      .first_byte    (req_tuser),
      .section_bytes (req_tdata[19:8]),
      .cfg_wr        (csr_valid && csr_ready),
      .cfg_index     (csr_index),
      .cfg_data      (csr_data),
      .res           (res)
   );

   // Queue results toward the rsp port
   tsmp_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (item),
      .can_accept (can_accept)
   );

   // Pack the result payload
   assign rsp_tdata = {6'b00_0000, item.status, item.stream_kind, item.stream_pid};
   assign rsp_tuser = item.kind;
   assign rsp_tlast = item.last;

endmodule

`default_nettype wire
